### src/rac_pkg.sv
package rac_pkg;

    localparam int SIZE_W   = 25;
    localparam int REGION_W = 16;
    localparam int ACTION_W = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] SIZE_MAX   = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(25'd16777216);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_OPEN_WRITE    = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_OPEN_READ     = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_CLOSE         = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_RECLAIM_CHECK = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_FLUSH         = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEANUP       = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_RESET         = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_DETACH        = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_ATTACH        = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PENDING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEVFAIL  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_NUMBER = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SIZE_W-1:0]   alloc_size;
        logic                close_is_write;
        logic                close_phys;
        logic                device_ok;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   alloc_offset;
        logic [REGION_W-1:0] region_out;
        logic                phys_read;
        logic                region_idle;
        logic                write_request;
        logic                cleanup_request;
        logic [SIZE_W-1:0]   item_total;
    } result_t;

endpackage

### src/rac_in_stage.sv
module rac_in_stage
    import rac_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### src/rac_engine.sv
module rac_engine
    import rac_pkg::*;
#(
    parameter int MAX_OPENS = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  item_t               item,
    input  logic [SIZE_W-1:0]   region_size,
    input  logic [REGION_W-1:0] region_number,
    output result_t             res
);

    localparam int CW = $clog2(MAX_OPENS + 1);
    localparam logic [CW-1:0] OPEN_LIMIT = CW'(MAX_OPENS);

    logic [CW-1:0]     writer_count_reg, writer_count_next;
    logic [CW-1:0]     phys_count_reg, phys_count_next;
    logic [CW-1:0]     mem_count_reg, mem_count_next;
    logic              blocked_reg, blocked_next;
    logic              flushed_reg, flushed_next;
    logic              cleaned_reg, cleaned_next;
    logic              attached_reg, attached_next;
    logic [SIZE_W-1:0] fill_offset_reg, fill_offset_next;
    logic [SIZE_W-1:0] item_count_reg, item_count_next;

    logic [SIZE_W:0]   fill_sum;
    logic              fits;

    assign fill_sum = {1'b0, fill_offset_reg} + {1'b0, item.alloc_size};
    assign fits     = fill_sum <= {1'b0, region_size};

    always_comb begin
        writer_count_next = writer_count_reg;
        phys_count_next   = phys_count_reg;
        mem_count_next    = mem_count_reg;
        blocked_next      = blocked_reg;
        flushed_next      = flushed_reg;
        cleaned_next      = cleaned_reg;
        attached_next     = attached_reg;
        fill_offset_next  = fill_offset_reg;
        item_count_next   = item_count_reg;

        res.status          = ST_OK;
        res.alloc_offset    = '0;
        res.region_out      = region_number;
        res.phys_read       = 1'b0;
        res.region_idle     = 1'b0;
        res.write_request   = 1'b0;
        res.cleanup_request = 1'b0;

        case (item.action)
            ACT_OPEN_WRITE: begin
                if (blocked_reg) begin
                    res.status = ST_BLOCKED;
                end else if (!fits) begin
                    res.status = ST_NO_SPACE;
                end else if (writer_count_reg >= OPEN_LIMIT) begin
                    res.status = ST_BUSY;
                end else begin
                    writer_count_next = writer_count_reg + 1'b1;
                    res.alloc_offset  = fill_offset_reg;
                    fill_offset_next  = fill_sum[SIZE_W-1:0];
                    if (item_count_reg != SIZE_MAX) begin
                        item_count_next = item_count_reg + 1'b1;
                    end
                end
            end
            ACT_OPEN_READ: begin
                if (blocked_reg) begin
                    res.status = ST_BLOCKED;
                end else if (flushed_reg || !attached_reg) begin
                    // no in-memory copy to serve from: go to the device
                    if (phys_count_reg >= OPEN_LIMIT) begin
                        res.status = ST_BUSY;
                    end else begin
                        phys_count_next = phys_count_reg + 1'b1;
                        res.phys_read   = 1'b1;
                    end
                end else if (mem_count_reg >= OPEN_LIMIT) begin
                    res.status = ST_BUSY;
                end else begin
                    mem_count_next = mem_count_reg + 1'b1;
                end
            end
            ACT_CLOSE: begin
                if (item.close_is_write) begin
                    if (writer_count_reg != '0) begin
                        writer_count_next = writer_count_reg - 1'b1;
                    end
                end else if (item.close_phys) begin
                    if (phys_count_reg != '0) begin
                        phys_count_next = phys_count_reg - 1'b1;
                    end
                end else if (mem_count_reg != '0) begin
                    mem_count_next = mem_count_reg - 1'b1;
                end
            end
            ACT_RECLAIM_CHECK: begin
                blocked_next    = 1'b1;
                res.region_idle = (writer_count_reg == '0) && (phys_count_reg == '0)
                                  && (mem_count_reg == '0);
            end
            ACT_FLUSH: begin
                if (writer_count_reg != '0) begin
                    res.status = ST_PENDING;
                end else if (!flushed_reg) begin
                    if (!attached_reg) begin
                        res.status = ST_DEVFAIL;
                    end else begin
                        res.write_request = 1'b1;
                        if (item.device_ok) begin
                            flushed_next = 1'b1;
                        end else begin
                            res.status = ST_DEVFAIL;
                        end
                    end
                end
            end
            ACT_CLEANUP: begin
                if (writer_count_reg != '0) begin
                    res.status = ST_PENDING;
                end else if (!cleaned_reg) begin
                    res.cleanup_request = attached_reg;
                    cleaned_next        = 1'b1;
                end
            end
            ACT_RESET: begin
                writer_count_next = '0;
                phys_count_next   = '0;
                mem_count_next    = '0;
                blocked_next      = 1'b0;
                flushed_next      = 1'b0;
                cleaned_next      = 1'b0;
                fill_offset_next  = '0;
                item_count_next   = '0;
            end
            ACT_DETACH: begin
                if (mem_count_reg != '0) begin
                    res.status = ST_BUSY;
                end else if (writer_count_reg != '0) begin
                    res.status = ST_PENDING;
                end else begin
                    attached_next = 1'b0;
                end
            end
            ACT_ATTACH: begin
                attached_next = 1'b1;
            end
            default: begin
            end
        endcase

        res.item_total = item_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            writer_count_reg <= '0;
            phys_count_reg   <= '0;
            mem_count_reg    <= '0;
            blocked_reg      <= 1'b0;
            flushed_reg      <= 1'b0;
            cleaned_reg      <= 1'b0;
            attached_reg     <= 1'b0;
            fill_offset_reg  <= '0;
            item_count_reg   <= '0;
        end else if (fire) begin
            writer_count_reg <= writer_count_next;
            phys_count_reg   <= phys_count_next;
            mem_count_reg    <= mem_count_next;
            blocked_reg      <= blocked_next;
            flushed_reg      <= flushed_next;
            cleaned_reg      <= cleaned_next;
            attached_reg     <= attached_next;
            fill_offset_reg  <= fill_offset_next;
            item_count_reg   <= item_count_next;
        end
    end

endmodule

### src/rac_out_stage.sv
module rac_out_stage
    import rac_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            res_reg <= res;
        end
    end

endmodule

### src/region_access_controller.sv
// Region access controller: bookkeeping for one storage region.
// Input channel (s_valid/s_ready) carries one action per item; the result
// channel (m_valid/m_ready) returns exactly one result per action, in order.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 region_size, 1 region_number) at the clock edge; write only while idle.
// Path: an accepted item goes through the input register, then the action
// logic into the result register, where its result can be taken.
// Throughput: one item per cycle while m_ready does not stall the result; the
// region state is updated in the same cycle the action leaves the input
// register, so back-to-back actions see each other's effects.
// Stall: when m_ready is low the result register holds; the input register
// still takes one more item, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): counters, flags, fill offset and item
// count clear, no buffer is attached, region_size returns to 16777216 and
// region_number to 0; both channels come out empty.
module region_access_controller
    import rac_pkg::*;
#(
    parameter int MAX_OPENS = 255
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [SIZE_W-1:0]    s_alloc_size,
    input  logic                 s_close_is_write,
    input  logic                 s_close_phys,
    input  logic                 s_device_ok,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [SIZE_W-1:0]    m_alloc_offset,
    output logic [REGION_W-1:0]  m_region_out,
    output logic                 m_phys_read,
    output logic                 m_region_idle,
    output logic                 m_write_request,
    output logic                 m_cleanup_request,
    output logic [SIZE_W-1:0]    m_item_total
);

    logic [SIZE_W-1:0]   region_size_reg;
    logic [REGION_W-1:0] region_number_reg;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    result_t res;
    result_t m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_size_reg   <= SIZE_RESET;
            region_number_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_REGION_SIZE:   region_size_reg   <= cfg_data;
                CFG_REGION_NUMBER: region_number_reg <= cfg_data[REGION_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_item.action         = s_action;
    assign s_item.alloc_size     = s_alloc_size;
    assign s_item.close_is_write = s_close_is_write;
    assign s_item.close_phys     = s_close_phys;
    assign s_item.device_ok      = s_device_ok;

    rac_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    rac_engine #(
        .MAX_OPENS (MAX_OPENS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (item_valid && can_load),
        .item          (item),
        .region_size   (region_size_reg),
        .region_number (region_number_reg),
        .res           (res)
    );

    rac_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (item_valid),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_status          = m_res.status;
    assign m_alloc_offset    = m_res.alloc_offset;
    assign m_region_out      = m_res.region_out;
    assign m_phys_read       = m_res.phys_read;
    assign m_region_idle     = m_res.region_idle;
    assign m_write_request   = m_res.write_request;
    assign m_cleanup_request = m_res.cleanup_request;
    assign m_item_total      = m_res.item_total;

endmodule

### src/rac_checker.sv
module rac_checker
    import rac_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [SIZE_W-1:0]   m_alloc_offset,
    input logic                m_phys_read,
    input logic                m_region_idle,
    input logic                m_write_request,
    input logic                m_cleanup_request,
    input logic [SIZE_W-1:0]   m_item_total
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_alloc_offset) && $stable(m_item_total))
        else $error("stalled result changed");

    // each action raises at most one of the side flags
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_phys_read, m_region_idle, m_write_request,
                                m_cleanup_request}) <= 1)
        else $error("more than one result flag set");

    // a nonzero offset, a device read or a cleanup request only comes with ok status
    a_offset_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_alloc_offset != '0 || m_phys_read || m_cleanup_request)
            |-> m_status == ST_OK)
        else $error("grant reported with a non-ok status");

endmodule

bind region_access_controller rac_checker u_rac_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_alloc_offset    (m_alloc_offset),
    .m_phys_read       (m_phys_read),
    .m_region_idle     (m_region_idle),
    .m_write_request   (m_write_request),
    .m_cleanup_request (m_cleanup_request),
    .m_item_total      (m_item_total)
);

### dv/region_access_controller_tb.sv
`timescale 1ns / 1ps

module region_access_controller_tb;
    import rac_pkg::*;

    localparam int MAX_OPENS   = 255;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 5;

    // codes past the last defined action: no effect on the region
    localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_LAST_CODE    = 4'hF;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } dir_row_t;

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 cfg_wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index         = '0;
    logic [SIZE_W-1:0]    cfg_data          = '0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [ACTION_W-1:0]  s_action          = '0;
    logic [SIZE_W-1:0]    s_alloc_size      = '0;
    logic                 s_close_is_write  = 1'b0;
    logic                 s_close_phys      = 1'b0;
    logic                 s_device_ok       = 1'b0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [SIZE_W-1:0]    m_alloc_offset;
    logic [REGION_W-1:0]  m_region_out;
    logic                 m_phys_read;
    logic                 m_region_idle;
    logic                 m_write_request;
    logic                 m_cleanup_request;
    logic [SIZE_W-1:0]    m_item_total;

    // region state as the testbench sees it
    logic [SIZE_W-1:0]   cfg_size   = SIZE_RESET;
    logic [REGION_W-1:0] cfg_number = '0;
    int                  wr_open    = 0;
    int                  phys_open  = 0;
    int                  mem_open   = 0;
    bit                  is_blocked = 1'b0;
    bit                  is_flushed = 1'b0;
    bit                  is_cleaned = 1'b0;
    bit                  has_buffer = 1'b0;
    logic [SIZE_W-1:0]   fill_off   = '0;
    logic [SIZE_W-1:0]   items_done = '0;

    result_t  expected_results[$];
    dir_row_t dir_rows[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       tx_idle_pct    = 0;
    int       rx_stall_pct   = 0;

    region_access_controller #(
        .MAX_OPENS(MAX_OPENS)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_alloc_size     (s_alloc_size),
        .s_close_is_write (s_close_is_write),
        .s_close_phys     (s_close_phys),
        .s_device_ok      (s_device_ok),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_alloc_offset   (m_alloc_offset),
        .m_region_out     (m_region_out),
        .m_phys_read      (m_phys_read),
        .m_region_idle    (m_region_idle),
        .m_write_request  (m_write_request),
        .m_cleanup_request(m_cleanup_request),
        .m_item_total     (m_item_total)
    );

    always #2 aclk = ~aclk;

    function automatic item_t mk_item(input logic [ACTION_W-1:0] action,
                                      input logic [SIZE_W-1:0] size,
                                      input bit is_write, input bit phys,
                                      input bit dev_ok);
        item_t it;
        it.action         = action;
        it.alloc_size     = size;
        it.close_is_write = is_write;
        it.close_phys     = phys;
        it.device_ok      = dev_ok;
        return it;
    endfunction

    // region_out is zero for these: the directed rows run with reset registers
    function automatic result_t mk_result(input logic [STATUS_W-1:0] status,
                                          input logic [SIZE_W-1:0] offset,
                                          input bit phys, input bit idle,
                                          input bit wreq, input bit creq,
                                          input logic [SIZE_W-1:0] total);
        result_t r;
        r.status          = status;
        r.alloc_offset    = offset;
        r.region_out      = '0;
        r.phys_read       = phys;
        r.region_idle     = idle;
        r.write_request   = wreq;
        r.cleanup_request = creq;
        r.item_total      = total;
        return r;
    endfunction

    function automatic void clear_region();
        wr_open    = 0;
        phys_open  = 0;
        mem_open   = 0;
        is_blocked = 1'b0;
        is_flushed = 1'b0;
        is_cleaned = 1'b0;
        fill_off   = '0;
        items_done = '0;
    endfunction

    // applies one action to the region state and returns its result
    function automatic result_t region_predict(input item_t it);
        result_t         r;
        logic [SIZE_W:0] end_off;
        r        = '0;
        r.status = ST_OK;
        end_off  = {1'b0, fill_off} + {1'b0, it.alloc_size};
        case (it.action)
            ACT_OPEN_WRITE: begin
                if (is_blocked) begin
                    r.status = ST_BLOCKED;
                end else if (end_off > {1'b0, cfg_size}) begin
                    r.status = ST_NO_SPACE;
                end else if (wr_open >= MAX_OPENS) begin
                    r.status = ST_BUSY;
                end else begin
                    wr_open++;
                    r.alloc_offset = fill_off;
                    fill_off = end_off[SIZE_W-1:0];
                    if (items_done != SIZE_MAX)
                        items_done = items_done + 1'b1;
                end
            end
            ACT_OPEN_READ: begin
                if (is_blocked) begin
                    r.status = ST_BLOCKED;
                end else if (is_flushed || !has_buffer) begin
                    if (phys_open >= MAX_OPENS) begin
                        r.status = ST_BUSY;
                    end else begin
                        phys_open++;
                        r.phys_read = 1'b1;
                    end
                end else if (mem_open >= MAX_OPENS) begin
                    r.status = ST_BUSY;
                end else begin
                    mem_open++;
                end
            end
            ACT_CLOSE: begin
                if (it.close_is_write) begin
                    if (wr_open != 0) wr_open--;
                end else if (it.close_phys) begin
                    if (phys_open != 0) phys_open--;
                end else begin
                    if (mem_open != 0) mem_open--;
                end
            end
            ACT_RECLAIM_CHECK: begin
                is_blocked    = 1'b1;
                r.region_idle = (wr_open == 0 && phys_open == 0 && mem_open == 0);
            end
            ACT_FLUSH: begin
                if (wr_open != 0) begin
                    r.status = ST_PENDING;
                end else if (!is_flushed) begin
                    if (!has_buffer) begin
                        r.status = ST_DEVFAIL;
                    end else begin
                        r.write_request = 1'b1;
                        if (it.device_ok)
                            is_flushed = 1'b1;
                        else
                            r.status = ST_DEVFAIL;
                    end
                end
            end
            ACT_CLEANUP: begin
                if (wr_open != 0) begin
                    r.status = ST_PENDING;
                end else if (!is_cleaned) begin
                    r.cleanup_request = has_buffer;
                    is_cleaned = 1'b1;
                end
            end
            ACT_RESET: begin
                clear_region();
            end
            ACT_DETACH: begin
                if (mem_open != 0)
                    r.status = ST_BUSY;
                else if (wr_open != 0)
                    r.status = ST_PENDING;
                else
                    has_buffer = 1'b0;
            end
            ACT_ATTACH: begin
                has_buffer = 1'b1;
            end
            default: begin
            end
        endcase
        r.region_out = cfg_number;
        r.item_total = items_done;
        return r;
    endfunction

    // mostly legal lifecycles: closes usually hit an open counter, sizes mostly fit
    function automatic item_t rand_item();
        item_t it;
        int    pick;
        int    roll;
        it.close_is_write = 1'($urandom_range(1));
        it.close_phys     = 1'($urandom_range(1));
        it.device_ok      = ($urandom_range(3) != 0);
        pick = $urandom_range(99);
        if (pick < 26)      it.action = ACT_OPEN_WRITE;
        else if (pick < 42) it.action = ACT_OPEN_READ;
        else if (pick < 66) it.action = ACT_CLOSE;
        else if (pick < 70) it.action = ACT_RECLAIM_CHECK;
        else if (pick < 78) it.action = ACT_FLUSH;
        else if (pick < 84) it.action = ACT_CLEANUP;
        else if (pick < 89) it.action = ACT_RESET;
        else if (pick < 93) it.action = ACT_DETACH;
        else if (pick < 98) it.action = ACT_ATTACH;
        else it.action = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_CODE));

        roll = $urandom_range(99);
        if (roll < 50)
            it.alloc_size = SIZE_W'($urandom_range(64));
        else if (roll < 70)
            it.alloc_size = SIZE_W'($urandom_range(cfg_size));
        else if (roll < 85)
            it.alloc_size = (fill_off <= cfg_size) ? cfg_size - fill_off : '0;
        else if (roll < 95)
            it.alloc_size = SIZE_W'($urandom_range(SIZE_RESET));
        else
            it.alloc_size = SIZE_RESET;

        if (it.action == ACT_CLOSE && $urandom_range(9) < 7) begin
            if (wr_open != 0 && $urandom_range(1)) begin
                it.close_is_write = 1'b1;
            end else if (phys_open != 0 && (mem_open == 0 || $urandom_range(1))) begin
                it.close_is_write = 1'b0;
                it.close_phys     = 1'b1;
            end else if (mem_open != 0) begin
                it.close_is_write = 1'b0;
                it.close_phys     = 1'b0;
            end
        end
        return it;
    endfunction

    function automatic string fmt_result(input result_t r);
        return $sformatf("st=%0d off=%0d reg=%0d phys=%0b idle=%0b wreq=%0b creq=%0b tot=%0d",
                         r.status, r.alloc_offset, r.region_out, r.phys_read,
                         r.region_idle, r.write_request, r.cleanup_request,
                         r.item_total);
    endfunction

    // entered just after a rising edge; returns at the edge that took the item
    task automatic send_item(input item_t it, input bit use_given, input result_t given);
        result_t pred;
        @(negedge aclk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= it.action;
        s_alloc_size     <= it.alloc_size;
        s_close_is_write <= it.close_is_write;
        s_close_phys     <= it.close_phys;
        s_device_ok      <= it.device_ok;
        do
            @(posedge aclk);
        while (!s_ready);
        pred = region_predict(it);
        expected_results.push_back(use_given ? given : pred);
    endtask

    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        if (idx == CFG_REGION_SIZE)
            cfg_size = data;
        else if (idx == CFG_REGION_NUMBER)
            cfg_number = data[REGION_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(negedge aclk)
        m_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_alloc_offset, m_region_out, m_phys_read, m_region_idle,
                   m_write_request, m_cleanup_request, m_item_total};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: %s", fmt_result(got));
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result mismatch at cycle %0d", cycle_count);
                        $display("  exp %s", fmt_result(want));
                        $display("  got %s", fmt_result(got));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int      ph;
        int      n;
        result_t none;
        none = '0;

        // no buffer yet, empty region, reset registers
        dir_rows.push_back('{mk_item(ACT_FLUSH, 0, 0, 0, 1), 1'b1,
                             mk_result(ST_DEVFAIL, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(ACT_OPEN_READ, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 1, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(ACT_CLOSE, 0, 0, 1, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 0)});
        // closing counters already at zero is ignored
        dir_rows.push_back('{mk_item(ACT_CLOSE, 0, 1, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(ACT_CLOSE, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 0)});
        // whole region, then a zero-size item at the very end, then no space
        dir_rows.push_back('{mk_item(ACT_OPEN_WRITE, SIZE_RESET, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_item(ACT_OPEN_WRITE, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, SIZE_RESET, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_OPEN_WRITE, 1, 0, 0, 0), 1'b1,
                             mk_result(ST_NO_SPACE, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_FLUSH, 0, 0, 0, 1), 1'b1,
                             mk_result(ST_PENDING, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_CLEANUP, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_PENDING, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_ATTACH, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_DETACH, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_PENDING, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_OPEN_READ, 0, 0, 0, 0), 1'b0, none});
        dir_rows.push_back('{mk_item(ACT_DETACH, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_BUSY, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_CLOSE, 0, 1, 0, 0), 1'b0, none});
        dir_rows.push_back('{mk_item(ACT_CLOSE, 0, 1, 1, 0), 1'b0, none});
        dir_rows.push_back('{mk_item(ACT_CLOSE, 0, 0, 0, 0), 1'b0, none});
        // device failure still issues the write
        dir_rows.push_back('{mk_item(ACT_FLUSH, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_DEVFAIL, 0, 0, 0, 1, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_FLUSH, 0, 0, 0, 1), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 1, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_FLUSH, 0, 0, 0, 1), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_OPEN_READ, 0, 0, 0, 0), 1'b0, none});
        dir_rows.push_back('{mk_item(ACT_CLEANUP, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 1, 2)});
        dir_rows.push_back('{mk_item(ACT_CLEANUP, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_RECLAIM_CHECK, 0, 0, 0, 0), 1'b0, none});
        dir_rows.push_back('{mk_item(ACT_OPEN_WRITE, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_BLOCKED, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_OPEN_READ, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_BLOCKED, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_item(ACT_LAST_CODE, SIZE_MAX, 1, 1, 1), 1'b0, none});
        // reset with a reader still open
        dir_rows.push_back('{mk_item(ACT_RESET, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(ACT_DETACH, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(ACT_CLEANUP, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(ACT_RECLAIM_CHECK, 0, 0, 0, 0), 1'b1,
                             mk_result(ST_OK, 0, 0, 1, 0, 0, 0)});

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

        // drive each counter into its open limit
        tx_idle_pct  = 33;
        rx_stall_pct = 33;
        send_item(mk_item(ACT_RESET, 0, 0, 0, 0), 1'b0, none);
        send_item(mk_item(ACT_DETACH, 0, 0, 0, 0), 1'b0, none);
        repeat (MAX_OPENS + 2)
            send_item(mk_item(ACT_OPEN_READ, 0, 0, 0, 0), 1'b0, none);
        send_item(mk_item(ACT_RESET, 0, 0, 0, 0), 1'b0, none);
        send_item(mk_item(ACT_ATTACH, 0, 0, 0, 0), 1'b0, none);
        repeat (MAX_OPENS + 2)
            send_item(mk_item(ACT_OPEN_READ, 0, 0, 0, 0), 1'b0, none);
        send_item(mk_item(ACT_RESET, 0, 0, 0, 0), 1'b0, none);
        repeat (MAX_OPENS + 2)
            send_item(mk_item(ACT_OPEN_WRITE, 0, 0, 0, 0), 1'b0, none);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            pause_until_drained();
            case (ph)
                0: begin
                    cfg_write(CFG_REGION_SIZE, 1);
                    cfg_write(CFG_REGION_NUMBER, {9'h1FF, 16'hFFFF});
                end
                1: begin
                    cfg_write(CFG_REGION_SIZE, 4096);
                    cfg_write(CFG_REGION_NUMBER, SIZE_W'($urandom_range(16'hFFFF)));
                end
                2: begin
                    cfg_write(CFG_REGION_SIZE, SIZE_RESET);
                    cfg_write(CFG_REGION_NUMBER, '0);
                end
                3: begin
                    cfg_write(CFG_REGION_SIZE, SIZE_W'($urandom_range(1, SIZE_RESET)));
                    cfg_write(CFG_REGION_NUMBER, SIZE_W'($urandom));
                end
                default: begin
                    cfg_write(CFG_REGION_SIZE, SIZE_W'($urandom_range(64, 1024)));
                    cfg_write(CFG_REGION_NUMBER, SIZE_W'($urandom_range(16'hFFFF)));
                end
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    pause_until_drained();
                send_item(rand_item(), 1'b0, none);
            end
        end

        pause_until_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
